// File: hdl/assert_macros.svh
// Assertion helpers used by spd_queue. Every macro samples on clk_i and is
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define SPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// An implication that must hold in the same cycle.
`define SPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// An implication that must hold in the following cycle.
`define SPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/spd_pkg.sv
package spd_pkg;

  localparam int SPD_MAX_PAYLOAD = 32;
  localparam int NUM_KINDS       = 4;
  localparam int LEN_W           = 7;
  localparam int IDX_MAX_W       = 6;
  localparam int CFG_IDX_W       = 3;

  localparam logic [7:0] SYNC_FIRST  = 8'h2A;
  localparam logic [7:0] SYNC_SECOND = 8'h40;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_KIND0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_KIND3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_KIND0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_KIND3  = 3'd7;

  localparam logic [NUM_KINDS-1:0][7:0] CODE_RST = {8'd4, 8'd3, 8'd2, 8'd1};
  localparam logic [NUM_KINDS-1:0][5:0] LEN_RST  = {6'd4, 6'd4, 6'd4, 6'd8};

  typedef struct packed {
    logic [1:0]       kind;
    logic [LEN_W-1:0] len;
    logic             bank;
  } spd_cmd_t;

  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [IDX_MAX_W-1:0] idx;
    logic [7:0]           data;
  } spd_wr_t;

endpackage

// File: hdl/spd_front.sv
module spd_front
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = SPD_MAX_PAYLOAD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  output logic                 in_ready_o,
  input  logic                 q_full_i,
  output logic                 push_o,
  output spd_cmd_t             cmd_o,
  output spd_wr_t              wr_o
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_SYNC2 = 2'd1;
  localparam logic [1:0] PH_CODE  = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  logic [NUM_KINDS-1:0][7:0] code_q;
  logic [NUM_KINDS-1:0][5:0] len_q;

  logic [1:0]       phase_q, phase_d;
  logic [1:0]       kind_q, kind_d;
  logic [CNT_W-1:0] exp_len_q, exp_len_d;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic [7:0]       sum_q, sum_d;
  logic             bank_q, bank_d;

  logic             accept;
  logic             hit;
  logic [1:0]       hit_kind;
  logic [5:0]       sel_len;
  logic [CNT_W-1:0] sat_len;
  logic             body_more;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign body_more  = seen_q < exp_len_q;

  // The lowest kind number wins when several codes match.
  always_comb begin
    hit      = 1'b0;
    hit_kind = 2'd0;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if (code_q[k] == in_byte_i) begin
        hit      = 1'b1;
        hit_kind = 2'(k);
      end
    end
  end

  assign sel_len = len_q[hit_kind];

  always_comb begin
    if ({1'b0, sel_len} > 7'(MAX_PAYLOAD)) begin
      sat_len = CNT_W'(MAX_PAYLOAD);
    end else begin
      sat_len = CNT_W'(sel_len);
    end
  end

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    exp_len_d = exp_len_q;
    seen_d    = seen_q;
    sum_d     = sum_q;
    bank_d    = bank_q;
    push_o    = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_HUNT: begin
          if (in_byte_i == SYNC_FIRST) begin
            phase_d = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          phase_d = (in_byte_i == SYNC_SECOND) ? PH_CODE : PH_HUNT;
        end
        PH_CODE: begin
          phase_d = PH_HUNT;
          if (hit) begin
            kind_d    = hit_kind;
            exp_len_d = sat_len;
            seen_d    = '0;
            sum_d     = in_byte_i;
            phase_d   = PH_BODY;
          end
        end
        default: begin
          if (body_more) begin
            sum_d  = sum_q + in_byte_i;
            seen_d = seen_q + CNT_W'(1);
          end else begin
            phase_d = PH_HUNT;
            if (in_byte_i == sum_q && seen_q != '0) begin
              push_o = 1'b1;
              bank_d = !bank_q;
            end
          end
        end
      endcase
    end
  end

  assign wr_o.en   = accept && (phase_q == PH_BODY) && body_more;
  assign wr_o.bank = bank_q;
  assign wr_o.idx  = IDX_MAX_W'(seen_q);
  assign wr_o.data = in_byte_i;

  assign cmd_o.kind = kind_q;
  assign cmd_o.len  = LEN_W'(seen_q);
  assign cmd_o.bank = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q    <= CODE_RST;
      len_q     <= LEN_RST;
      phase_q   <= PH_HUNT;
      kind_q    <= '0;
      exp_len_q <= '0;
      seen_q    <= '0;
      sum_q     <= '0;
      bank_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i >= REG_CODE_KIND0 && cfg_index_i <= REG_CODE_KIND3) begin
          code_q[cfg_index_i[1:0]] <= cfg_wdata_i;
        end else if (cfg_index_i >= REG_LEN_KIND0 && cfg_index_i <= REG_LEN_KIND3) begin
          len_q[cfg_index_i[1:0]] <= cfg_wdata_i[5:0];
        end
      end
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      exp_len_q <= exp_len_d;
      seen_q    <= seen_d;
      sum_q     <= sum_d;
      bank_q    <= bank_d;
    end
  end

endmodule

// File: hdl/spd_queue.sv
`include "assert_macros.svh"

module spd_queue
  import spd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  spd_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output spd_cmd_t cmd_o
);

  // One entry per payload bank, so a full queue means both banks are taken.
  spd_cmd_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  `SPD_ASSERT_IMPL(a_no_overflow, push_i, !full_o)
  `SPD_ASSERT_IMPL(a_no_underflow, pop_i, valid_o)
  `SPD_ASSERT(a_cnt_range, cnt_q != 2'd3)
  `SPD_ASSERT_NEXT(a_ptr_gap, cnt_q == 2'd0 && !push_i, wr_ptr_q == rd_ptr_q)

endmodule

// File: hdl/spd_back.sv
module spd_back
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = SPD_MAX_PAYLOAD
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spd_wr_t    wr_i,
  input  logic       q_valid_i,
  input  spd_cmd_t   cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [4:0] out_index_o,
  output logic       out_last_o
);

  localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int MEM_DEPTH = 2 * (2 ** IDX_W);
  localparam int ADDR_W    = IDX_W + 1;

  logic [7:0] mem_q [MEM_DEPTH];
  logic [7:0] rd_data_q;

  logic             pend_q, pend_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;

  logic             issue;
  logic             load;
  logic             is_last;
  logic [LEN_W-1:0] idx_ext;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign wr_addr = {wr_i.bank, wr_i.idx[IDX_W-1:0]};
  assign rd_addr = {cmd_i.bank, idx_q[IDX_W-1:0]};

  // A read is issued into rd_data_q, then moved into the output register once it is empty or being taken.
  assign issue   = q_valid_i && !pend_q;
  assign load    = pend_q && (!valid_q || out_ready_i);
  assign idx_ext = LEN_W'(idx_q);
  assign is_last = (idx_ext + LEN_W'(1)) == cmd_i.len;
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr] <= wr_i.data;
    end
    if (issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    pend_d  = pend_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (issue) begin
      pend_d = 1'b1;
    end
    if (load) begin
      pend_d  = 1'b0;
      valid_d = 1'b1;
      idx_d   = is_last ? '0 : idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_o  <= cmd_i.kind;
      out_byte_o  <= rd_data_q;
      out_index_o <= idx_ext[4:0];
      out_last_o  <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;

endmodule

// File: hdl/serial_packet_deframer.sv
// After the checksum byte is accepted, the frame is queued, read from the store and loaded out.
// Input: one byte per cycle; s_axis_tready drops only while two verified frames wait.
// Output: each payload item is read from the registered payload store and then loaded
// into the output register; the next read is issued only after that load.
// Reset: control state clears and the codes and lengths return to their defaults;
// the payload store is not cleared.
module serial_packet_deframer
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = SPD_MAX_PAYLOAD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: rx_byte[7:0]
  input  logic [7:0]           s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: payload_byte[7:0], byte_index[12:8], zero[15:13]
  output logic [15:0]          m_axis_tdata,
  // tuser: packet_kind[1:0]
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  spd_cmd_t   push_cmd, head_cmd;
  spd_wr_t    wr;
  logic       push, pop, q_full, q_valid;
  logic [7:0] out_byte;
  logic [4:0] out_index;

  spd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .wr_o       (wr)
  );

  spd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  spd_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .q_valid_i  (q_valid),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_kind_o (m_axis_tuser),
    .out_byte_o (out_byte),
    .out_index_o(out_index),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_index, out_byte};

endmodule
